@@ hdl/stsp_pkg.sv @@
`default_nettype none

package stsp_pkg;

	// Result kinds as they appear on the output tuser.
	typedef enum logic [1:0] {
		KIND_TOKEN = 2'd0,
		KIND_TEND  = 2'd1,
		KIND_EOI   = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;

	// Queue between classifier and serializer.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int MAX_RES     = 4;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} slot_t;

	// One classified input byte: up to four results in emission order.
	typedef struct packed {
		logic [2:0]  cnt;
		slot_t [3:0] slot;
	} plan_t;

	// Queue status seen by the classifier.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
	endfunction

	function automatic logic is_special(input logic [7:0] c);
		return c == 8'h7B || c == 8'h7D || c == 8'h5B || c == 8'h5D ||
			c == 8'h28 || c == 8'h29 || c == 8'h3B;
	endfunction

	// Appends one result to a plan.
	function automatic plan_t add_result(input plan_t p, input kind_t k, input logic [7:0] d);
		plan_t r;
		r = p;
		r.slot[p.cnt[1:0]].kind = k;
		r.slot[p.cnt[1:0]].data = d;
		r.cnt = p.cnt + 3'd1;
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hdl/stsp_front.sv @@
`default_nettype none

module stsp_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [7:0]      in_ch,
	input  wire logic            in_end,
	input  wire stsp_pkg::qstat_t qstat,
	output logic                 push,
	output stsp_pkg::plan_t      push_plan
);

	logic in_comment_q, in_string_q, skipping_q, token_open_q, tilde_q;
	logic in_comment_d, in_string_d, skipping_d, token_open_d, tilde_d;
	logic open_v;
	stsp_pkg::plan_t p;

	assign in_ready = !qstat.full;

	// Classify the byte against the lexer state and build its result list.
	always_comb begin
		in_comment_d = in_comment_q;
		in_string_d  = in_string_q;
		skipping_d   = skipping_q;
		token_open_d = token_open_q;
		tilde_d      = tilde_q;
		open_v       = token_open_q;
		p            = '0;
		if (in_end) begin
			if (in_string_q) begin
				p = stsp_pkg::add_result(p, stsp_pkg::KIND_ERROR, 8'd0);
			end else begin
				if (tilde_q)
					p = stsp_pkg::add_result(p, stsp_pkg::KIND_TOKEN, stsp_pkg::CH_TILDE);
				if (tilde_q || token_open_q)
					p = stsp_pkg::add_result(p, stsp_pkg::KIND_TEND, 8'd0);
				p = stsp_pkg::add_result(p, stsp_pkg::KIND_EOI, 8'd0);
			end
			in_comment_d = 1'b0;
			in_string_d  = 1'b0;
			skipping_d   = 1'b0;
			token_open_d = 1'b0;
			tilde_d      = 1'b0;
		end else if (in_comment_q) begin
			if (in_ch == stsp_pkg::CH_LF)
				in_comment_d = 1'b0;
		end else if (in_string_q) begin
			if (in_ch == stsp_pkg::CH_QUOTE) begin
				p = stsp_pkg::add_result(p, stsp_pkg::KIND_TEND, 8'd0);
				in_string_d  = 1'b0;
				token_open_d = 1'b0;
			end else begin
				p = stsp_pkg::add_result(p, stsp_pkg::KIND_TOKEN, in_ch);
			end
		end else if (skipping_q) begin
			if (stsp_pkg::is_ws(in_ch)) begin
				skipping_d = 1'b0;
			end else if (stsp_pkg::is_special(in_ch)) begin
				skipping_d = 1'b0;
				p = stsp_pkg::add_result(p, stsp_pkg::KIND_TOKEN, in_ch);
				p = stsp_pkg::add_result(p, stsp_pkg::KIND_TEND, 8'd0);
			end
		end else if (tilde_q && in_ch == stsp_pkg::CH_TILDE) begin
			tilde_d      = 1'b0;
			in_comment_d = 1'b1;
		end else begin
			// A held tilde is released in front of any other byte.
			if (tilde_q) begin
				tilde_d = 1'b0;
				p = stsp_pkg::add_result(p, stsp_pkg::KIND_TOKEN, stsp_pkg::CH_TILDE);
				open_v = 1'b1;
			end
			token_open_d = open_v;
			if (stsp_pkg::is_ws(in_ch)) begin
				if (open_v)
					p = stsp_pkg::add_result(p, stsp_pkg::KIND_TEND, 8'd0);
				token_open_d = 1'b0;
			end else if (stsp_pkg::is_special(in_ch)) begin
				if (open_v)
					p = stsp_pkg::add_result(p, stsp_pkg::KIND_TEND, 8'd0);
				p = stsp_pkg::add_result(p, stsp_pkg::KIND_TOKEN, in_ch);
				p = stsp_pkg::add_result(p, stsp_pkg::KIND_TEND, 8'd0);
				token_open_d = 1'b0;
			end else if (in_ch == stsp_pkg::CH_QUOTE) begin
				if (open_v)
					p = stsp_pkg::add_result(p, stsp_pkg::KIND_TEND, 8'd0);
				p = stsp_pkg::add_result(p, stsp_pkg::KIND_TOKEN, in_ch);
				in_string_d  = 1'b1;
				token_open_d = 1'b1;
			end else if (!open_v && in_ch >= stsp_pkg::CH_LOW_A &&
					in_ch <= stsp_pkg::CH_LOW_Z) begin
				skipping_d = 1'b1;
			end else if (!open_v && in_ch == stsp_pkg::CH_TILDE) begin
				tilde_d = 1'b1;
			end else begin
				p = stsp_pkg::add_result(p, stsp_pkg::KIND_TOKEN, in_ch);
				token_open_d = 1'b1;
			end
		end
	end

	// Items with no results never enter the queue.
	assign push      = in_valid && in_ready && p.cnt != 3'd0;
	assign push_plan = p;

	// Lexer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_comment_q <= 1'b0;
			in_string_q  <= 1'b0;
			skipping_q   <= 1'b0;
			token_open_q <= 1'b0;
			tilde_q      <= 1'b0;
		end else if (in_valid && in_ready) begin
			in_comment_q <= in_comment_d;
			in_string_q  <= in_string_d;
			skipping_q   <= skipping_d;
			token_open_q <= token_open_d;
			tilde_q      <= tilde_d;
		end
	end

endmodule

`default_nettype wire

@@ hdl/stsp_queue.sv @@
`default_nettype none

module stsp_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire stsp_pkg::plan_t  push_plan,
	input  wire logic             pop,
	output stsp_pkg::plan_t       head,
	output stsp_pkg::qstat_t      qstat
);

	localparam int PTR_W = stsp_pkg::QPTR_W;
	localparam int CNT_W = stsp_pkg::QPTR_W + 1;

	stsp_pkg::plan_t mem_q [stsp_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign qstat.full  = count_q == CNT_W'(stsp_pkg::QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;
	assign head        = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_plan;
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

@@ hdl/stsp_back.sv @@
`default_nettype none

module stsp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire stsp_pkg::plan_t  head,
	input  wire stsp_pkg::qstat_t qstat,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [1:0]            out_kind,
	output logic [7:0]            out_data,
	output logic                  out_last
);

	stsp_pkg::plan_t cur_q;
	logic            cur_valid_q;
	logic [1:0]      idx_q;
	logic            done;

	// Current result of the plan being sent.
	assign out_valid = cur_valid_q;
	assign out_kind  = cur_q.slot[idx_q].kind;
	assign out_data  = cur_q.slot[idx_q].data;
	assign out_last  = ({1'b0, idx_q} + 3'd1) == cur_q.cnt;

	assign done = !cur_valid_q || (out_ready && out_last);
	assign pop  = done && !qstat.empty;

	// Plan holding register and slot index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (done) begin
			cur_valid_q <= !qstat.empty;
			idx_q       <= '0;
		end else if (out_ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
	end

endmodule

`default_nettype wire

@@ hdl/script_token_splitter.sv @@
`default_nettype none

// Channel  Dir  tdata            tuser      tlast
// s_*      in   [7:0] ch         -          is_end
// m_*      out  [7:0] data       [1:0] kind last
//
// An input byte is taken every cycle while the four-entry plan queue has room.
// Each byte yields zero to four results; the serializer sends one result per
// cycle while m_tready is high, so throughput is one byte per cycle when bytes
// give at most one result. Results pass the queue, then the plan register.
// Reset clears the lexer state and empties the queue; no clearing pass is needed.
// A stalled output fills the queue, after which s_tready falls.

module script_token_splitter (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] ch
	input  wire logic       s_tlast,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] data
	output logic [1:0]      m_tuser,   // [1:0] kind
	output logic            m_tlast
);

	stsp_pkg::qstat_t qstat;
	stsp_pkg::plan_t  push_plan, head;
	logic             push, pop;

	stsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_ch     (s_tdata),
		.in_end    (s_tlast),
		.qstat     (qstat),
		.push      (push),
		.push_plan (push_plan)
	);

	stsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_plan (push_plan),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	stsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

	// The queue is never written while full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("plan queue written while full");

	// Only token bytes carry data.
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != stsp_pkg::KIND_TOKEN |-> m_tdata == 8'd0)
		else $error("non-token result with data");

	// End of input and string errors always close an item's results.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == stsp_pkg::KIND_EOI || m_tuser == stsp_pkg::KIND_ERROR)
		|-> m_tlast)
		else $error("end result not marked last");

	// A popped plan is never empty.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.cnt != 3'd0)
		else $error("empty plan in queue");

endmodule

`default_nettype wire
